// File: hdl/gnn_pkg.sv
// Shared types, constants and codes for the grouped nearest-neighbor search.
package gnn_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int MAX_DIMS        = 4;
	localparam int COORD_BITS      = 16;
	localparam int SQ_W            = 2 * COORD_BITS;
	localparam int DIST_W          = 34;
	localparam int ORD_W           = 8;
	localparam int DIMS_W          = 3;
	localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd4;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} gnn_state_t;

	typedef struct packed {
		logic [1:0] cmd;
		coord_t     group_key;
		coord_t     coord_a;
		coord_t     coord_b;
		coord_t     coord_c;
		coord_t     coord_d;
	} gnn_in_t;

	typedef struct packed {
		logic              found;
		logic [ORD_W-1:0]  group_index;
		logic [DIST_W-1:0] best_distance_sq;
		logic              table_overflowed;
	} gnn_out_t;

	typedef struct packed {
		coord_t                     key;
		coord_t [MAX_DIMS-1:0]      coords;
	} gnn_entry_t;

	// lane stage status handed to the merge stage
	typedef struct packed {
		logic start;
		logic valid;
		logic match;
	} gnn_stage_t;

	// running best of the merge stage
	typedef struct packed {
		logic              busy;
		logic              any;
		logic [ORD_W-1:0]  ord;
		logic [DIST_W-1:0] dist_sq;
	} gnn_best_t;

endpackage

// File: hdl/gnn_lane.sv
// One distance lane: squared difference of one coordinate, registered.
module gnn_lane (
	input  logic                    clk,
	input  logic                    en,
	input  gnn_pkg::coord_t         q_coord,
	input  gnn_pkg::coord_t         r_coord,
	output logic [gnn_pkg::SQ_W-1:0] sq_s2
);
	import gnn_pkg::*;

	logic signed [COORD_BITS:0]     diff;
	logic signed [2*COORD_BITS+1:0] prod;

	always_comb begin
		diff = {q_coord[COORD_BITS-1], q_coord} - {r_coord[COORD_BITS-1], r_coord};
		prod = diff * diff;
	end

	// square of a 17-bit difference always fits in SQ_W unsigned bits
	always_ff @(posedge clk) begin
		sq_s2 <= en ? prod[SQ_W-1:0] : '0;
	end

endmodule

// File: hdl/gnn_merge.sv
// Merge stage: sums the lane squares and keeps the nearest match of the group.
module gnn_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gnn_pkg::gnn_stage_t                   stage,
	input  logic [gnn_pkg::MAX_DIMS-1:0][gnn_pkg::SQ_W-1:0] sq,
	output gnn_pkg::gnn_best_t                    best
);
	import gnn_pkg::*;

	logic [DIST_W-1:0] sum;
	logic [DIST_W-1:0] sum_s3;
	logic              valid_s3;
	logic              match_s3;
	logic              any_q;
	logic [ORD_W-1:0]  ord_q;
	logic [ORD_W-1:0]  best_ord_q;
	logic [DIST_W-1:0] best_dist_q;
	logic              take;

	always_comb begin
		sum = '0;
		for (int j = 0; j < MAX_DIMS; j++) begin
			sum = sum + DIST_W'(sq[j]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			match_s3 <= 1'b0;
		end else begin
			valid_s3 <= stage.valid;
			match_s3 <= stage.match;
		end
	end

	// strict compare: the earliest point keeps a tie
	assign take = valid_s3 && match_s3 && (!any_q || sum_s3 < best_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
			ord_q <= '0;
		end else if (stage.start) begin
			any_q <= 1'b0;
			ord_q <= '0;
		end else if (valid_s3 && match_s3) begin
			any_q <= 1'b1;
			ord_q <= ord_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_ord_q  <= ord_q;
			best_dist_q <= sum_s3;
		end
	end

	always_comb begin
		best.busy    = valid_s3;
		best.any     = any_q;
		best.ord     = best_ord_q;
		best.dist_sq = best_dist_q;
	end

endmodule

// File: hdl/grouped_nearest_neighbor.sv
// Top level: point table, query scan control and result register.
// A query reads the stored table from one memory port, one entry per cycle,
// over all N points loaded so far; four coordinate lanes and a merge stage
// follow, and the result is ready once they have drained (an empty table
// skips the scan). Commands are stalled while a query scans and until its
// result is loaded into the result register. The result register lets the
// next command in while a result still waits to be taken.
module grouped_nearest_neighbor #(
	parameter int TABLE_DEPTH = gnn_pkg::TABLE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  gnn_pkg::gnn_in_t            cmd_data,
	output logic                        res_valid,
	input  logic                        res_stall,
	output gnn_pkg::gnn_out_t           res_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [gnn_pkg::DIMS_W-1:0]  cfg_data
);
	import gnn_pkg::*;

	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	gnn_entry_t mem [TABLE_DEPTH];

	gnn_state_t  state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [DIMS_W-1:0] dims_q;
	logic [DIMS_W-1:0] act_dims;
	logic [ADDR_W-1:0] rd_idx_q;
	logic              cmd_acc;
	logic              is_load, is_query, is_clear;
	logic              last_rd;
	logic              res_load;
	logic              valid_s1, valid_s2, match_s2;
	gnn_entry_t        rd_s1;
	gnn_entry_t        query_q;
	logic [MAX_DIMS-1:0] lane_en;
	logic [MAX_DIMS-1:0][SQ_W-1:0] sq_s2;
	gnn_stage_t        stage;
	gnn_best_t         best;

	assign cfg_ready = 1'b1;
	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign is_clear  = cmd_acc && (cmd_data.cmd == CMD_CLEAR);
	assign is_load   = cmd_acc && (cmd_data.cmd == CMD_LOAD);
	assign is_query  = cmd_acc && (cmd_data.cmd == CMD_QUERY);
	assign last_rd   = (CNT_W'(rd_idx_q) + 1'b1) == cnt_q;
	assign res_load  = (state_q == ST_DONE) && (!res_valid || !res_stall);

	// dims register clamped to 1..MAX_DIMS
	always_comb begin
		if (dims_q == '0)
			act_dims = DIMS_W'(1);
		else if (dims_q > DIMS_W'(MAX_DIMS))
			act_dims = DIMS_W'(MAX_DIMS);
		else
			act_dims = dims_q;
		for (int j = 0; j < MAX_DIMS; j++) begin
			lane_en[j] = DIMS_W'(j) < act_dims;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dims_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (is_clear) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (is_load) begin
			if (cnt_q >= CNT_W'(TABLE_DEPTH))
				ovf_q <= 1'b1;
			else
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (is_load && cnt_q < CNT_W'(TABLE_DEPTH)) begin
			mem[cnt_q[ADDR_W-1:0]] <= '{key: cmd_data.group_key,
				coords: {cmd_data.coord_d, cmd_data.coord_c,
				         cmd_data.coord_b, cmd_data.coord_a}};
		end
		rd_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			query_q <= '{key: cmd_data.group_key,
				coords: {cmd_data.coord_d, cmd_data.coord_c,
				         cmd_data.coord_b, cmd_data.coord_a}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			match_s2 <= 1'b0;
		end else begin
			state_q  <= state_d;
			if (is_query)
				rd_idx_q <= '0;
			else if (state_q == ST_SCAN)
				rd_idx_q <= rd_idx_q + 1'b1;
			valid_s1 <= (state_q == ST_SCAN);
			valid_s2 <= valid_s1;
			match_s2 <= valid_s1 && (rd_s1.key == query_q.key);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (is_query)
					state_d = (cnt_q == '0) ? ST_DONE : ST_SCAN;
			end
			ST_SCAN: begin
				if (last_rd)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!valid_s1 && !valid_s2 && !best.busy)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	for (genvar j = 0; j < MAX_DIMS; j++) begin : g_lane
		gnn_lane u_lane (
			.clk     (clk),
			.en      (lane_en[j]),
			.q_coord (query_q.coords[j]),
			.r_coord (rd_s1.coords[j]),
			.sq_s2   (sq_s2[j])
		);
	end

	always_comb begin
		stage.start = is_query;
		stage.valid = valid_s2;
		stage.match = match_s2;
	end

	gnn_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.stage  (stage),
		.sq     (sq_s2),
		.best   (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (res_load) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_data.found            <= best.any;
			res_data.group_index      <= best.any ? best.ord : '0;
			res_data.best_distance_sq <= best.any ? best.dist_sq : '0;
			res_data.table_overflowed <= ovf_q;
		end
	end

endmodule

// File: verif/gnn_check_pkg.sv
// Point table tracker and answer checker for the grouped nearest-neighbor testbench.
`timescale 1ns / 100ps
package gnn_check_pkg;
	import gnn_pkg::*;

	// unused command code, ignored by the block
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	class point_table_model;
		coord_t            keys[TABLE_DEPTH_DEF];
		coord_t            coords[TABLE_DEPTH_DEF][MAX_DIMS];
		int unsigned       stored;
		bit                overflowed;
		logic [DIMS_W-1:0] dims_reg;
		gnn_out_t          answers_due[$];
		int unsigned       mismatches;

		function new();
			stored     = 0;
			overflowed = 1'b0;
			dims_reg   = DIMS_RESET;
			mismatches = 0;
		endfunction

		function void set_dims(logic [DIMS_W-1:0] value);
			dims_reg = value;
		endfunction

		function gnn_out_t nearest_in_group(gnn_in_t q);
			gnn_out_t          r;
			coord_t            qc[MAX_DIMS];
			int unsigned       used;
			int unsigned       ord;
			longint            diff;
			longint unsigned   sum;
			qc[0] = q.coord_a;
			qc[1] = q.coord_b;
			qc[2] = q.coord_c;
			qc[3] = q.coord_d;
			if (dims_reg == 0)
				used = 1;
			else if (dims_reg > MAX_DIMS)
				used = MAX_DIMS;
			else
				used = dims_reg;
			r   = '0;
			ord = 0;
			for (int i = 0; i < stored; i++) begin
				if (keys[i] == q.group_key) begin
					sum = 0;
					for (int j = 0; j < used; j++) begin
						diff = longint'(qc[j]) - longint'(coords[i][j]);
						sum += longint'(diff * diff);
					end
					// strict less keeps the earliest point on a tie
					if (!r.found || sum < r.best_distance_sq) begin
						r.found            = 1'b1;
						r.group_index      = ORD_W'(ord);
						r.best_distance_sq = DIST_W'(sum);
					end
					ord++;
				end
			end
			r.table_overflowed = overflowed;
			return r;
		endfunction

		function void accept_command(gnn_in_t c);
			case (c.cmd)
				CMD_CLEAR: begin
					stored     = 0;
					overflowed = 1'b0;
				end
				CMD_LOAD: begin
					if (stored >= TABLE_DEPTH_DEF) begin
						overflowed = 1'b1;
					end else begin
						keys[stored]      = c.group_key;
						coords[stored][0] = c.coord_a;
						coords[stored][1] = c.coord_b;
						coords[stored][2] = c.coord_c;
						coords[stored][3] = c.coord_d;
						stored++;
					end
				end
				CMD_QUERY: answers_due.push_back(nearest_in_group(c));
				default: ;
			endcase
		endfunction

		task flag_mismatch(string what);
			mismatches++;
			$display("MISMATCH at %0t: %s", $time, what);
		endtask

		task check_answer(gnn_out_t got);
			gnn_out_t want;
			if (answers_due.size() == 0) begin
				flag_mismatch($sformatf("result %h with no query pending", got));
				return;
			end
			want = answers_due.pop_front();
			if (got.found !== want.found)
				flag_mismatch($sformatf("found %b, want %b", got.found, want.found));
			if (got.group_index !== want.group_index)
				flag_mismatch($sformatf("group_index %0d, want %0d",
					got.group_index, want.group_index));
			if (got.best_distance_sq !== want.best_distance_sq)
				flag_mismatch($sformatf("best_distance_sq %0d, want %0d",
					got.best_distance_sq, want.best_distance_sq));
			if (got.table_overflowed !== want.table_overflowed)
				flag_mismatch($sformatf("table_overflowed %b, want %b",
					got.table_overflowed, want.table_overflowed));
		endtask
	endclass

endpackage

// File: verif/grouped_nearest_neighbor_test.sv
// Testbench top: drives commands and dims writes, checks query answers against a tracked table.
`timescale 1ns / 100ps
module grouped_nearest_neighbor_test;
	import gnn_pkg::*;
	import gnn_check_pkg::*;

	localparam int     HALF_PERIOD   = 4;
	localparam int     RESET_CYCLES  = 7;
	localparam longint CYCLE_LIMIT   = 1_500_000;
	localparam int     DRAIN_CYCLES  = 8;
	localparam int     SETTLE_CYCLES = 300;	// longer than a full-table scan
	localparam int     LONG_HOLD     = 1500;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              cmd_valid  = 1'b0;
	logic              cmd_stall;
	gnn_in_t           cmd_data   = '0;
	logic              res_valid;
	logic              res_stall  = 1'b0;
	gnn_out_t          res_data;
	logic              cfg_valid  = 1'b0;
	logic              cfg_ready;
	logic [DIMS_W-1:0] cfg_data   = '0;

	point_table_model book = new();
	gnn_in_t          loaded_pts[$];	// points actually held in the table
	int unsigned      items_sent     = 0;
	int unsigned      send_idle_pct  = 0;
	int unsigned      recv_stall_pct = 0;
	int               hold_left      = 0;
	longint           cycle_count    = 0;

	grouped_nearest_neighbor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("grouped_nearest_neighbor_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			book.check_answer(res_data);
	end

	// result side: a long hold when asked, random stalls otherwise
	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic gnn_in_t make_item(logic [1:0] op, coord_t k, coord_t a, coord_t b,
		coord_t c, coord_t d);
		gnn_in_t it;
		it.cmd       = op;
		it.group_key = k;
		it.coord_a   = a;
		it.coord_b   = b;
		it.coord_c   = c;
		it.coord_d   = d;
		return it;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(5))
			0: return coord_t'(16'h8000);
			1: return coord_t'(16'h7FFF);
			2, 3: return coord_t'($urandom);
			default: return coord_t'(int'($urandom_range(512)) - 256);
		endcase
	endfunction

	function automatic coord_t nudge(coord_t base);
		return coord_t'(int'(base) + int'($urandom_range(64)) - 32);
	endfunction

	task automatic send_cmd(gnn_in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd_data  <= item;
		do @(posedge clk); while (cmd_stall);
		book.accept_command(item);
		if (item.cmd != CMD_UNUSED)
			items_sent++;
		if (item.cmd == CMD_CLEAR)
			loaded_pts.delete();
		else if (item.cmd == CMD_LOAD && loaded_pts.size() < TABLE_DEPTH_DEF)
			loaded_pts.push_back(item);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (book.answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(logic [DIMS_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		book.set_dims(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_query(coord_t keys[4], int n_keys);
		gnn_in_t q;
		gnn_in_t p;
		q = make_item(CMD_QUERY, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord());
		if ($urandom_range(4) != 0)
			q.group_key = keys[$urandom_range(n_keys - 1)];
		if (loaded_pts.size() != 0 && $urandom_range(9) < 6) begin
			p = loaded_pts[$urandom_range(loaded_pts.size() - 1)];
			if ($urandom_range(2) != 0)
				q.group_key = p.group_key;
			if ($urandom_range(2) == 0) begin
				q.coord_a = p.coord_a;
				q.coord_b = p.coord_b;
				q.coord_c = p.coord_c;
				q.coord_d = p.coord_d;
			end else begin
				q.coord_a = nudge(p.coord_a);
				q.coord_b = nudge(p.coord_b);
				q.coord_c = nudge(p.coord_c);
				q.coord_d = nudge(p.coord_d);
			end
		end
		send_cmd(q);
	endtask

	// one load-query sequence, mostly after a clear, with random content and some noise
	task automatic random_burst(bit fill);
		coord_t  keys[4];
		int      n_keys;
		int      n_pts;
		int      n_q;
		gnn_in_t p;
		if ($urandom_range(9) != 0)
			send_cmd(make_item(CMD_CLEAR, rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord()));
		n_keys = $urandom_range(1, 4);
		for (int i = 0; i < 4; i++)
			keys[i] = ($urandom_range(1) != 0) ? rand_coord()
				: coord_t'($urandom_range(3) << 8);
		n_pts = fill ? $urandom_range(257, 300) : $urandom_range(0, 20);
		for (int i = 0; i < n_pts; i++) begin
			p = make_item(CMD_LOAD, keys[$urandom_range(n_keys - 1)], rand_coord(),
				rand_coord(), rand_coord(), rand_coord());
			// duplicates make ties
			if (loaded_pts.size() != 0 && $urandom_range(4) == 0) begin
				p = loaded_pts[$urandom_range(loaded_pts.size() - 1)];
				p.cmd = CMD_LOAD;
			end
			send_cmd(p);
			if (!fill && $urandom_range(5) == 0)
				send_query(keys, n_keys);
			if ($urandom_range(15) == 0)
				send_cmd(make_item(CMD_UNUSED, rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord()));
		end
		n_q = $urandom_range(1, 8);
		for (int i = 0; i < n_q; i++)
			send_query(keys, n_keys);
		if ($urandom_range(4) == 0)
			wait_drained();
	endtask

	task automatic run_phase(logic [DIMS_W-1:0] dims, int unsigned s_idle,
		int unsigned r_stall, int unsigned n, bit fill_first, bit long_hold);
		int unsigned target;
		bit          fill;
		wait_drained();
		write_dims(dims);
		send_idle_pct  = s_idle;
		recv_stall_pct = r_stall;
		if (long_hold) begin
			@(posedge clk);
			hold_left = LONG_HOLD;
		end
		target = items_sent + n;
		fill   = fill_first;
		while (items_sent < target) begin
			random_burst(fill);
			fill = 1'b0;
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, field extremes, tie, empty group, unused code, clear
		send_cmd(make_item(CMD_QUERY, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
		send_cmd(make_item(CMD_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
		send_cmd(make_item(CMD_LOAD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		send_cmd(make_item(CMD_LOAD, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		send_cmd(make_item(CMD_QUERY, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		send_cmd(make_item(CMD_QUERY, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
		send_cmd(make_item(CMD_QUERY, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
		send_cmd(make_item(CMD_LOAD, 16'sh0000, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000));
		send_cmd(make_item(CMD_LOAD, 16'sh0000, -16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000));
		send_cmd(make_item(CMD_QUERY, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
		send_cmd(make_item(CMD_QUERY, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
		send_cmd(make_item(CMD_UNUSED, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF));
		send_cmd(make_item(CMD_CLEAR, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
		send_cmd(make_item(CMD_QUERY, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));

		// dims, sender idle %, receiver stall %, items, start with a full table, long hold
		run_phase(3'd1,  0,  0, 180, 1'b1, 1'b0);
		run_phase(3'd4, 67,  0, 110, 1'b0, 1'b0);
		run_phase(3'd0,  0, 67, 110, 1'b0, 1'b0);
		run_phase(3'd7, 16, 16, 110, 1'b0, 1'b0);
		run_phase(3'd2,  0,  0, 100, 1'b0, 1'b1);
		run_phase(3'd3,  0, 67, 140, 1'b1, 1'b0);
		run_phase(3'd5,  0,  0,  60, 1'b0, 1'b0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.mismatches == 0)
			$display("grouped_nearest_neighbor_test: done, clean");
		else
			$display("grouped_nearest_neighbor_test: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
hdl/gnn_pkg.sv
hdl/gnn_lane.sv
hdl/gnn_merge.sv
hdl/grouped_nearest_neighbor.sv
verif/gnn_check_pkg.sv
verif/grouped_nearest_neighbor_test.sv
